// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int HEX_BITS        = 4;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BAD_SIZE  = 3'd1,
    CAUSE_TOO_BIG   = 3'd2,
    CAUSE_BAD_TERM  = 3'd3,
    CAUSE_TRUNCATED = 3'd4
  } cause_t;

  typedef enum logic [10:0] {
    PH_LEAD     = 11'b000_0000_0001,
    PH_DIGITS   = 11'b000_0000_0010,
    PH_TAIL     = 11'b000_0000_0100,
    PH_EXT      = 11'b000_0000_1000,
    PH_DATA     = 11'b000_0001_0000,
    PH_DATA_END = 11'b000_0010_0000,
    PH_DATA_CR  = 11'b000_0100_0000,
    PH_TR_START = 11'b000_1000_0000,
    PH_TR_CR    = 11'b001_0000_0000,
    PH_TR_BODY  = 11'b010_0000_0000,
    PH_IDLE     = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data;
    cause_t      cause;
    logic [31:0] body_length;
    logic [31:0] consumed;
  } step_t;

  // Returns {digit valid, digit value}.
  function automatic logic [HEX_BITS:0] hex_val(input logic [7:0] c);
    logic [HEX_BITS:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, HEX_BITS'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, HEX_BITS'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, HEX_BITS'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

// ===== design/hcbd_parser.sv =====
module hcbd_parser #(
  parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,
  input  logic [7:0]     byte_in,
  input  logic           last,
  output hcbd_pkg::step_t step
);
  import hcbd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] body_r, body_nxt;
  logic [COUNT_WIDTH-1:0] cons_r, cons_nxt;
  logic [COUNT_WIDTH-1:0] cons_inc;
  logic [HEX_BITS:0]      hv;
  logic                   emit;
  kind_t                  kind;
  cause_t                 cause;
  logic [63:0]            body_ext;
  logic [63:0]            cons_ext;

  assign hv       = hex_val(byte_in);
  assign cons_inc = cons_r + CONE;
  assign body_ext = 64'(body_r);
  assign cons_ext = 64'(cons_inc);

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    body_nxt  = body_r;
    cons_nxt  = cons_r;
    emit      = 1'b0;
    kind      = KIND_BYTE;
    cause     = CAUSE_NONE;
    if (phase_r == PH_IDLE) begin
      emit = 1'b0;
    end else if (cons_r == CMAX) begin
      emit  = 1'b1;
      kind  = KIND_ERROR;
      cause = CAUSE_TOO_BIG;
    end else begin
      cons_nxt = cons_inc;
      unique case (phase_r) inside
        PH_LEAD, PH_DIGITS, PH_TAIL: begin
          if (phase_r != PH_TAIL && hv[HEX_BITS]) begin
            if (rem_r[COUNT_WIDTH-1 -: HEX_BITS] != '0) begin
              emit  = 1'b1;
              kind  = KIND_ERROR;
              cause = CAUSE_TOO_BIG;
            end else begin
              rem_nxt   = {rem_r[COUNT_WIDTH-HEX_BITS-1:0], hv[HEX_BITS-1:0]};
              phase_nxt = PH_DIGITS;
            end
          end else if (is_ws(byte_in)) begin
            if (phase_r == PH_DIGITS) phase_nxt = PH_TAIL;
          end else if (phase_r != PH_LEAD && byte_in == CH_SEMI) begin
            phase_nxt = PH_EXT;
          end else if (phase_r != PH_LEAD && byte_in == CH_LF) begin
            phase_nxt = (rem_r == '0) ? PH_TR_START : PH_DATA;
          end else begin
            emit  = 1'b1;
            kind  = KIND_ERROR;
            cause = CAUSE_BAD_SIZE;
          end
        end
        PH_EXT: begin
          if (byte_in == CH_LF) phase_nxt = (rem_r == '0) ? PH_TR_START : PH_DATA;
        end
        PH_DATA: begin
          if (body_r == CMAX) begin
            emit  = 1'b1;
            kind  = KIND_ERROR;
            cause = CAUSE_TOO_BIG;
          end else begin
            body_nxt = body_r + CONE;
            emit     = 1'b1;
            kind     = KIND_BYTE;
            rem_nxt  = rem_r - CONE;
            if (rem_r == CONE) phase_nxt = PH_DATA_END;
          end
        end
        PH_DATA_END: begin
          if (byte_in == CH_CR) begin
            phase_nxt = PH_DATA_CR;
          end else if (byte_in == CH_LF) begin
            phase_nxt = PH_LEAD;
          end else begin
            emit  = 1'b1;
            kind  = KIND_ERROR;
            cause = CAUSE_BAD_TERM;
          end
        end
        PH_DATA_CR: begin
          if (byte_in == CH_LF) begin
            phase_nxt = PH_LEAD;
          end else begin
            emit  = 1'b1;
            kind  = KIND_ERROR;
            cause = CAUSE_BAD_TERM;
          end
        end
        PH_TR_START: begin
          if (byte_in == CH_LF) begin
            emit = 1'b1;
            kind = KIND_DONE;
          end else if (byte_in == CH_CR) begin
            phase_nxt = PH_TR_CR;
          end else begin
            phase_nxt = PH_TR_BODY;
          end
        end
        PH_TR_CR: begin
          if (byte_in == CH_LF) begin
            emit = 1'b1;
            kind = KIND_DONE;
          end else begin
            phase_nxt = PH_TR_BODY;
          end
        end
        PH_TR_BODY: begin
          phase_nxt = (byte_in == CH_LF) ? PH_TR_START : PH_TR_BODY;
        end
        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase
    end

    if (phase_r != PH_IDLE && last && (!emit || kind == KIND_BYTE)) begin
      emit  = 1'b1;
      kind  = KIND_ERROR;
      cause = CAUSE_TRUNCATED;
    end
    if (emit && kind != KIND_BYTE) phase_nxt = PH_IDLE;
    if (last) begin
      phase_nxt = PH_LEAD;
      rem_nxt   = '0;
      body_nxt  = '0;
      cons_nxt  = '0;
    end
  end

  always_comb begin
    step.valid       = emit;
    step.kind        = kind;
    step.data        = (kind == KIND_BYTE) ? byte_in : 8'h00;
    step.cause       = cause;
    step.body_length = (kind == KIND_DONE) ? body_ext[31:0] : 32'h0;
    step.consumed    = (kind == KIND_DONE) ? cons_ext[31:0] : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      rem_r   <= '0;
      body_r  <= '0;
      cons_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      body_r  <= body_nxt;
      cons_r  <= cons_nxt;
    end
  end

  a_data_has_rem: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> rem_r != '0)
    else $error("data phase with no bytes left in the chunk");

  a_error_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && step.kind == KIND_ERROR |-> step.cause != CAUSE_NONE)
    else $error("error result without a cause");

  a_done_from_trailer: assert property (@(posedge clk) disable iff (!rst_n)
    step.valid && step.kind == KIND_DONE |-> (phase_r == PH_TR_START || phase_r == PH_TR_CR))
    else $error("completion outside the trailer");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    take && phase_r == PH_IDLE && !last |=> phase_r == PH_IDLE)
    else $error("left the drop state before the end of payload");

endmodule

// ===== design/hcbd_out_reg.sv =====
module hcbd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  hcbd_pkg::step_t step,
  input  logic            out_stall,
  output logic            out_valid,
  output hcbd_pkg::step_t res
);
  import hcbd_pkg::*;

  logic  valid_r, valid_nxt;
  step_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= step;
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// Latency: a result item appears in the cycle after the input item that causes it.
// Throughput: one input item per cycle while the input is not stalled; the parse state updates on each accepted item.
// The input stalls only while a result item waits in the output register and is stalled.
// Reset (rst_n low, synchronous) returns the parser to the size line and clears all counts.
// An item marked end_of_payload also returns the parser to that reset state.
module http_chunked_body_decoder #(
  parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data,
  output logic [2:0]  out_error_cause,
  output logic [31:0] out_body_length,
  output logic [31:0] out_consumed
);
  import hcbd_pkg::*;

  logic  take;
  step_t step;
  step_t res;

  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  hcbd_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .byte_in(in_byte_in),
    .last   (in_end_of_payload),
    .step   (step)
  );

  hcbd_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && step.valid),
    .step     (step),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .res      (res)
  );

  assign out_kind        = res.kind;
  assign out_data        = res.data;
  assign out_error_cause = res.cause;
  assign out_body_length = res.body_length;
  assign out_consumed    = res.consumed;

endmodule

// ===== tb/tb_http_chunked_body_decoder.sv =====
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder;
  import hcbd_pkg::*;

  typedef enum int {
    ACT_NONE,
    ACT_BYTE,
    ACT_DONE,
    ACT_ERR
  } act_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    cause_t      cause;
    logic [31:0] body_length;
    logic [31:0] consumed;
  } decoded_t;

  localparam logic [63:0] COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_end_of_payload = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data;
  logic [2:0]  out_error_cause;
  logic [31:0] out_body_length;
  logic [31:0] out_consumed;

  decoded_t   decoded_fifo[$];
  logic [7:0] msg_q[$];
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         bytes_offered = 0;
  int         mismatches = 0;
  logic       hold_on = 1'b0;
  event       hold_start;

  phase_t      ph;
  logic [63:0] chunk_left;
  logic [63:0] body_cnt;
  logic [63:0] used_cnt;

  http_chunked_body_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_in        (in_byte_in),
    .in_end_of_payload (in_end_of_payload),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_error_cause   (out_error_cause),
    .out_body_length   (out_body_length),
    .out_consumed      (out_consumed)
  );

  always #2 clk = ~clk;

  task automatic decoder_reset;
    ph = PH_LEAD;
    chunk_left = '0;
    body_cnt = '0;
    used_cnt = '0;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic last);
    act_t       act;
    cause_t     cause;
    logic       is_hex;
    logic       space;
    logic [3:0] nib;
    decoded_t   r;
    if (ph == PH_IDLE) begin
      if (last) begin
        decoder_reset();
      end
      return;
    end
    act = ACT_NONE;
    cause = CAUSE_NONE;
    is_hex = 1'b1;
    nib = '0;
    if (b >= "0" && b <= "9") begin
      nib = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      nib = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      nib = 4'(b - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
    space = (b == CH_SP) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    if (used_cnt >= COUNT_MAX) begin
      act = ACT_ERR;
      cause = CAUSE_TOO_BIG;
    end else begin
      used_cnt++;
      case (ph)
        PH_LEAD, PH_DIGITS, PH_TAIL: begin
          if (ph != PH_TAIL && is_hex) begin
            if (chunk_left > (COUNT_MAX >> 4)) begin
              act = ACT_ERR;
              cause = CAUSE_TOO_BIG;
            end else begin
              chunk_left = (chunk_left << 4) | 64'(nib);
              ph = PH_DIGITS;
            end
          end else if (space) begin
            if (ph == PH_DIGITS) begin
              ph = PH_TAIL;
            end
          end else if (ph != PH_LEAD && b == CH_SEMI) begin
            ph = PH_EXT;
          end else if (ph != PH_LEAD && b == CH_LF) begin
            ph = (chunk_left == 0) ? PH_TR_START : PH_DATA;
          end else begin
            act = ACT_ERR;
            cause = CAUSE_BAD_SIZE;
          end
        end
        PH_EXT: begin
          if (b == CH_LF) begin
            ph = (chunk_left == 0) ? PH_TR_START : PH_DATA;
          end
        end
        PH_DATA: begin
          if (body_cnt >= COUNT_MAX) begin
            act = ACT_ERR;
            cause = CAUSE_TOO_BIG;
          end else begin
            body_cnt++;
            act = ACT_BYTE;
            chunk_left--;
            if (chunk_left == 0) begin
              ph = PH_DATA_END;
            end
          end
        end
        PH_DATA_END: begin
          if (b == CH_CR) begin
            ph = PH_DATA_CR;
          end else if (b == CH_LF) begin
            ph = PH_LEAD;
          end else begin
            act = ACT_ERR;
            cause = CAUSE_BAD_TERM;
          end
        end
        PH_DATA_CR: begin
          if (b == CH_LF) begin
            ph = PH_LEAD;
          end else begin
            act = ACT_ERR;
            cause = CAUSE_BAD_TERM;
          end
        end
        PH_TR_START: begin
          if (b == CH_LF) begin
            act = ACT_DONE;
          end else if (b == CH_CR) begin
            ph = PH_TR_CR;
          end else begin
            ph = PH_TR_BODY;
          end
        end
        PH_TR_CR: begin
          if (b == CH_LF) begin
            act = ACT_DONE;
          end else begin
            ph = PH_TR_BODY;
          end
        end
        default: begin
          ph = (b == CH_LF) ? PH_TR_START : PH_TR_BODY;
        end
      endcase
    end
    // The end flag on a byte that neither finishes the body nor fails turns it into an error.
    if (last && (act == ACT_NONE || act == ACT_BYTE)) begin
      act = ACT_ERR;
      cause = CAUSE_TRUNCATED;
    end
    if (act != ACT_NONE) begin
      r = '0;
      if (act == ACT_BYTE) begin
        r.kind = KIND_BYTE;
        r.data = b;
      end else if (act == ACT_DONE) begin
        r.kind = KIND_DONE;
        r.body_length = body_cnt[31:0];
        r.consumed = used_cnt[31:0];
      end else begin
        r.kind = KIND_ERROR;
        r.cause = cause;
      end
      r.cause = cause;
      decoded_fifo.insert(decoded_fifo.size(), r);
      if (act != ACT_BYTE) begin
        ph = PH_IDLE;
      end
    end
    if (last) begin
      decoder_reset();
    end
  endtask

  task automatic report(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_out
    decoded_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_fifo.size() == 0) begin
        report($sformatf("result kind %0d with none expected", out_kind));
      end else begin
        e = decoded_fifo.pop_front();
        if (out_kind !== e.kind) begin
          report($sformatf("kind %0d, expected %0d", out_kind, e.kind));
        end
        if (out_data !== e.data) begin
          report($sformatf("data %h, expected %h", out_data, e.data));
        end
        if (out_error_cause !== e.cause) begin
          report($sformatf("cause %0d, expected %0d", out_error_cause, e.cause));
        end
        if (out_body_length !== e.body_length) begin
          report($sformatf("body length %0d, expected %0d", out_body_length, e.body_length));
        end
        if (out_consumed !== e.consumed) begin
          report($sformatf("consumed %0d, expected %0d", out_consumed, e.consumed));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < rcv_idle_pct);
  end

  initial begin
    forever begin
      @(hold_start);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte_in <= b;
    in_end_of_payload <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, last);
    bytes_offered++;
  endtask

  task automatic send_msg(input bit mark_end);
    foreach (msg_q[i]) begin
      send_byte(msg_q[i], mark_end && (i == msg_q.size() - 1));
    end
    msg_q.delete();
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic add_str(input string s);
    foreach (s[i]) begin
      add_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return "0" + 8'(v);
    end
    return ($urandom_range(1) ? "a" : "A") + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] ws_char;
    case ($urandom_range(4))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] not_lf_char;
    logic [7:0] b;
    do begin
      b = 8'($urandom);
    end while (b == CH_LF);
    return b;
  endfunction

  task automatic add_size_line(input int size);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) add_byte(ws_char());
    end
    if ($urandom_range(3) == 0) begin
      add_byte("0");
    end
    for (int s = 28; s >= 0; s -= 4) begin
      if ((size >> s) != 0 || s == 0) begin
        add_byte(hex_char(4'(size >> s)));
      end
    end
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(2, 1)) add_byte(ws_char());
    end
    if ($urandom_range(3) == 0) begin
      add_byte(CH_SEMI);
      repeat ($urandom_range(5)) add_byte(not_lf_char());
    end
    add_str($urandom_range(1) ? "\r\n" : "\n");
  endtask

  task automatic build_body(input int chunks, input int max_size);
    int size;
    repeat (chunks) begin
      size = $urandom_range(max_size, 1);
      add_size_line(size);
      repeat (size) add_byte(8'($urandom));
      add_str($urandom_range(1) ? "\r\n" : "\n");
    end
    add_size_line(0);
    repeat ($urandom_range(2)) begin
      if ($urandom_range(3) == 0) begin
        add_byte(CH_CR);
      end
      add_byte("X");
      repeat ($urandom_range(5)) add_byte(not_lf_char());
      add_byte(CH_LF);
    end
    add_str($urandom_range(1) ? "\r\n" : "\n");
  endtask

  task automatic add_noise;
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(10, 7)) add_byte(hex_char(4'($urandom)));
      add_byte(CH_LF);
      repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(10, 1)) begin
        case ($urandom_range(7))
          0: add_byte(hex_char(4'($urandom)));
          1: add_byte(ws_char());
          2: add_byte(CH_SEMI);
          3: add_byte(CH_LF);
          4: add_byte(CH_CR);
          default: add_byte(8'($urandom));
        endcase
      end
    end
  endtask

  task automatic test_directed_edges;
    add_str("1\n");
    add_byte(8'hFF);
    add_str("\n0\n\n");
    send_msg(1'b1);
    add_str(";");
    send_msg(1'b1);
    add_str("\n");
    send_msg(1'b1);
    add_str("100000000");
    send_msg(1'b1);
    add_str("1\n");
    add_byte(8'h00);
    add_str("xq");
    send_msg(1'b1);
    add_str("2\na");
    send_msg(1'b1);
  endtask

  task automatic test_random_bodies(input int n);
    int stop_at;
    int pick;
    int keep;
    stop_at = bytes_offered + n;
    while (bytes_offered < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        add_noise();
      end else begin
        build_body($urandom_range(4), ($urandom_range(99) < 10) ? 40 : 8);
        if (pick < 18) begin
          msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom);
        end else if (pick < 25) begin
          keep = $urandom_range(msg_q.size() - 1, 1);
          msg_q = msg_q[0:keep-1];
        end else if (pick < 30) begin
          repeat ($urandom_range(4, 1)) add_byte(8'($urandom));
        end
      end
      send_msg($urandom_range(99) >= 3);
    end
  endtask

  task automatic test_backpressure;
    drain();
    -> hold_start;
    add_size_line(24);
    repeat (24) add_byte(8'($urandom));
    add_str("\r\n0\r\n\r\n");
    send_msg(1'b1);
    drain();
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    decoder_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    snd_idle_pct = 30;
    rcv_idle_pct = 86;
    test_directed_edges();
    test_random_bodies(215);
    drain();

    snd_idle_pct = 86;
    rcv_idle_pct = 30;
    test_random_bodies(215);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random_bodies(215);

    @(negedge clk);
    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && decoded_fifo.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (decoded_fifo.size() != 0) begin
      $display("%0d expected results never arrived", decoded_fifo.size());
    end
    if (mismatches == 0 && decoded_fifo.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hcbd_pkg.sv
design/hcbd_parser.sv
design/hcbd_out_reg.sv
design/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
